// ----- design/idr_pkg.sv -----
// Shared types and constants for the id remap block.
package idr_pkg;

    localparam int CTX_W        = 4;
    localparam int ID_W         = 16;
    localparam int POOL_W       = 8;
    localparam int CONTEXTS_DEF = 16;
    localparam int MAX_ID_DEF   = 255;
    localparam logic [POOL_W-1:0] CAP_RESET = 8'd255;

    typedef struct packed {
        logic [CTX_W-1:0] context_index;
        logic             present;
        logic [ID_W-1:0]  in_schema_id;
        logic             in_recycled;
    } in_word_t;

    typedef struct packed {
        logic            out_present;
        logic [ID_W-1:0] out_schema_id;
        logic            out_recycled;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_OWNER,
        ST_DECIDE,
        ST_LINK1,
        ST_LINK2,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic decide;
        logic link1;
        logic link2;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic pass_in;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ----- design/idr_ctrl.sv -----
// Sequencer for the id remap block: clearing pass, lookup, LRU relink, output.
module idr_ctrl
    import idr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = sts.pass_in ? ST_FINISH : ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_OWNER;
            end
            ST_OWNER:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_LINK1;
            end
            ST_LINK1:
            begin
                cmd.link1  = 1'b1;
                state_next = ST_LINK2;
            end
            ST_LINK2:
            begin
                cmd.link2  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/idr_datapath.sv -----
// Datapath for the id remap block: entry, owner and LRU link memories.
module idr_datapath
    import idr_pkg::*;
#(
    parameter int CONTEXTS = CONTEXTS_DEF,
    parameter int MAX_ID   = MAX_ID_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  in_word_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_word_t         out_data,
    input  logic              cfg_valid,
    input  logic [POOL_W-1:0] cfg_data,
    input  ctrl_cmd_t         cmd,
    output ctrl_sts_t         sts
);

    localparam int EDEPTH = CONTEXTS * (MAX_ID + 1);
    localparam int EW     = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
    localparam int PDEPTH = 1 << POOL_W;

    typedef struct packed {
        logic              valid;
        logic [POOL_W-1:0] oid;
    } entry_t;

    entry_t            entry_mem [EDEPTH];
    logic [EW-1:0]     owner_mem [PDEPTH];
    logic [POOL_W-1:0] next_mem  [PDEPTH];
    logic [POOL_W-1:0] prev_mem  [PDEPTH];

    entry_t            entry_q;
    logic [EW-1:0]     owner_q;
    logic [POOL_W-1:0] next_q;
    logic [POOL_W-1:0] prev_q;

    logic [POOL_W-1:0] capacity_reg;
    logic [POOL_W-1:0] head_reg;
    logic [POOL_W-1:0] tail_reg;
    logic [POOL_W-1:0] count_reg;
    logic [EW-1:0]     clr_cnt_reg;
    logic              out_valid_reg;
    out_word_t         out_reg;

    logic              present_reg;
    logic [ID_W-1:0]   sid_reg;
    logic              rec_reg;
    logic              pass_reg;
    logic [EW-1:0]     e_reg;
    logic [POOL_W-1:0] oid_reg;
    logic              hit_reg;
    logic              alloc_reg;

    logic [31:0]       e_full;
    logic              pass_in;
    logic [POOL_W-1:0] cap_eff;
    logic              hit;
    logic              alloc;
    logic [POOL_W-1:0] oid_sel;
    logic [POOL_W-1:0] link_addr;
    logic              touch;
    logic              tail_link;

    assign e_full = 32'(in_data.context_index) * 32'(MAX_ID + 1)
                  + 32'(in_data.in_schema_id);
    assign pass_in = (in_data.in_schema_id == '0)
                  || (32'(in_data.in_schema_id) > 32'(MAX_ID))
                  || (32'(in_data.context_index) >= 32'(CONTEXTS));

    assign cap_eff = (capacity_reg == '0) ? POOL_W'(1) : capacity_reg;
    assign hit     = entry_q.valid && (owner_q == e_reg);
    assign alloc   = !hit && (count_reg < cap_eff);
    always_comb
    begin
        priority if (hit)
        begin
            oid_sel = entry_q.oid;
        end
        else if (alloc)
        begin
            oid_sel = count_reg + POOL_W'(1);
        end
        else
        begin
            oid_sel = head_reg;
        end
    end

    assign link_addr = cmd.decide ? oid_sel : oid_reg;
    assign touch     = !alloc_reg && (oid_reg != tail_reg);
    assign tail_link = touch || (alloc_reg && (count_reg != '0));

    assign sts.clear_last = (clr_cnt_reg == EW'(EDEPTH - 1));
    assign sts.pass_in    = pass_in;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // entry store
    always_ff @(posedge clk)
    begin
        entry_q <= entry_mem[cmd.clear ? clr_cnt_reg : e_reg];
        if (cmd.clear)
        begin
            entry_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.link1 && !hit_reg)
        begin
            entry_mem[e_reg] <= '{valid: 1'b1, oid: oid_reg};
        end
    end

    // owner store
    always_ff @(posedge clk)
    begin
        owner_q <= owner_mem[entry_q.oid];
        if (cmd.link1 && !hit_reg)
        begin
            owner_mem[oid_reg] <= e_reg;
        end
    end

    // LRU links
    always_ff @(posedge clk)
    begin
        next_q <= next_mem[link_addr];
        if (cmd.link1 && touch && (oid_reg != head_reg))
        begin
            next_mem[prev_q] <= next_q;
        end
        else if (cmd.link2 && tail_link)
        begin
            next_mem[tail_reg] <= oid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_q <= prev_mem[link_addr];
        if (cmd.link1 && touch)
        begin
            prev_mem[next_q] <= prev_q;
        end
        else if (cmd.link2 && tail_link)
        begin
            prev_mem[oid_reg] <= tail_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + EW'(1);
            end
            if (cmd.link1 && touch && (oid_reg == head_reg))
            begin
                head_reg <= next_q;
            end
            if (cmd.link2)
            begin
                if (alloc_reg && (count_reg == '0))
                begin
                    head_reg <= oid_reg;
                end
                if (alloc_reg || touch)
                begin
                    tail_reg <= oid_reg;
                end
                if (alloc_reg)
                begin
                    count_reg <= oid_reg;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            present_reg <= in_data.present;
            sid_reg     <= in_data.in_schema_id;
            rec_reg     <= in_data.in_recycled;
            pass_reg    <= pass_in;
            e_reg       <= e_full[EW-1:0];
        end
        if (cmd.decide)
        begin
            oid_reg   <= oid_sel;
            hit_reg   <= hit;
            alloc_reg <= alloc;
        end
        if (cmd.load_out)
        begin
            out_reg.out_present   <= present_reg;
            out_reg.out_schema_id <= pass_reg ? sid_reg : ID_W'(oid_reg);
            out_reg.out_recycled  <= (pass_reg || hit_reg) ? rec_reg : 1'b1;
        end
    end

endmodule

// ----- design/id_remap_lru_recycle.sv -----
// Top level of the per-context id remap block with LRU recycling.
// Translates (context, schema id) pairs onto a shared pool of up to 255 ids.
// A mapped word steps through entry read, owner read, decide, two LRU link
// writes and load into the output register; a pass-through word goes from
// acceptance straight to the load. The output register lets the next word
// be accepted while a result waits. After reset a clearing pass sweeps all
// CONTEXTS*(MAX_ID+1) entries (4096 by default) of the entry store before
// the first word is accepted; capacity writes are taken at any time.
module id_remap_lru_recycle
    import idr_pkg::*;
#(
    parameter int CONTEXTS = CONTEXTS_DEF,
    parameter int MAX_ID   = MAX_ID_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_word_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_word_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [POOL_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    idr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    idr_datapath #(
        .CONTEXTS (CONTEXTS),
        .MAX_ID   (MAX_ID)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the id remap block: scoreboard, random stimulus, LRU predictor.
module testbench;
    import idr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    class remap_scoreboard;
        bit [7:0]  capacity;
        bit        entry_valid [4096];
        bit [7:0]  entry_out_id [4096];
        bit [11:0] id_owner [256];
        bit [7:0]  lru_next [256];
        bit [7:0]  lru_prev [256];
        bit [7:0]  lru_head;
        bit [7:0]  lru_tail;
        bit [7:0]  allocated_count;
        out_word_t pending_words [$];
        int        errors;

        function new();
            capacity = CAP_RESET;
            lru_head = '0;
            lru_tail = '0;
            allocated_count = '0;
            errors = 0;
            foreach (entry_valid[i]) entry_valid[i] = 1'b0;
        endfunction

        function void touch(bit [7:0] id);
            if (id == lru_tail) return;
            if (id == lru_head) lru_head = lru_next[id];
            else lru_next[lru_prev[id]] = lru_next[id];
            lru_prev[lru_next[id]] = lru_prev[id];
            lru_next[lru_tail] = id;
            lru_prev[id] = lru_tail;
            lru_tail = id;
        endfunction

        function void note_input(in_word_t w);
            out_word_t r;
            bit [11:0] e;
            bit [7:0]  oid;
            bit [7:0]  cap;
            r.out_present = w.present;
            r.out_schema_id = w.in_schema_id;
            r.out_recycled = w.in_recycled;
            if (w.in_schema_id != 0 && w.in_schema_id <= MAX_ID_DEF)
            begin
                e = {w.context_index, w.in_schema_id[7:0]};
                oid = entry_out_id[e];
                if (entry_valid[e] && id_owner[oid] == e)
                begin
                    touch(oid);
                    r.out_schema_id = 16'(oid);
                end
                else
                begin
                    cap = (capacity == 0) ? 8'd1 : capacity;
                    if (allocated_count < cap)
                    begin
                        oid = allocated_count + 8'd1;
                        if (allocated_count == 0) lru_head = oid;
                        else
                        begin
                            lru_next[lru_tail] = oid;
                            lru_prev[oid] = lru_tail;
                        end
                        lru_tail = oid;
                        allocated_count = oid;
                    end
                    else
                    begin
                        oid = lru_head;
                        touch(oid);
                    end
                    id_owner[oid] = e;
                    entry_valid[e] = 1'b1;
                    entry_out_id[e] = oid;
                    r.out_schema_id = 16'(oid);
                    r.out_recycled = 1'b1;
                end
            end
            pending_words = {pending_words, r};
        endfunction

        function void check_result(out_word_t got);
            out_word_t x;
            if (pending_words.size() == 0)
            begin
                $error("unexpected word %h", got);
                errors++;
                return;
            end
            x = pending_words.pop_front();
            if (got.out_present !== x.out_present)
            begin
                $error("out_present exp %0d got %0d", x.out_present, got.out_present);
                errors++;
            end
            if (got.out_schema_id !== x.out_schema_id)
            begin
                $error("out_schema_id exp %0d got %0d", x.out_schema_id, got.out_schema_id);
                errors++;
            end
            if (got.out_recycled !== x.out_recycled)
            begin
                $error("out_recycled exp %0d got %0d", x.out_recycled, got.out_recycled);
                errors++;
            end
        endfunction
    endclass

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_stall;
    in_word_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 0;
    out_word_t out_data;
    logic      cfg_valid = 0;
    logic      cfg_ready;
    logic [POOL_W-1:0] cfg_data = '0;
    bit        quiet = 0;
    remap_scoreboard sb = new();

    id_remap_lru_recycle u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (out_valid && !out_stall) sb.check_result(out_data);
    end

    initial
    begin
        int burst;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 15);
                out_stall <= 1;
                repeat (burst) @(posedge clk);
            end
            out_stall <= 0;
        end
    end

    task automatic send_word(in_word_t w);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        in_data <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_input(w);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending_words.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_capacity(bit [7:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.capacity = v;
        cfg_valid <= 0;
    endtask

    function automatic in_word_t mk(bit [3:0] c, bit [15:0] id);
        in_word_t w;
        w.context_index = c;
        w.in_schema_id = id;
        w.present = 1'($urandom_range(0, 1));
        w.in_recycled = 1'($urandom_range(0, 1));
        return w;
    endfunction

    function automatic in_word_t rand_word(int span);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return mk(4'($urandom), 16'd0);
        if (k == 1) return mk(4'($urandom), 16'($urandom_range(256, 65535)));
        return mk(4'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1)),
                  16'($urandom_range(1, span)));
    endfunction

    initial
    begin
        bit [7:0] caps [6];
        caps = '{8'd255, 8'd1, 8'd0, 8'd4, 8'd16, 8'd200};
        repeat (7) @(posedge clk);
        rst_n <= 1;
        send_word(mk(4'd0, 16'd0));
        send_word(mk(4'd15, 16'd65535));
        send_word(mk(4'd15, 16'd256));
        send_word(mk(4'd0, 16'd1));
        send_word(mk(4'd0, 16'd1));
        send_word(mk(4'd15, 16'd255));
        send_word(mk(4'd3, 16'd255));
        send_word(mk(4'd15, 16'd255));
        send_word(mk(4'd7, 16'd128));
        drain();
        write_capacity(8'd2);
        for (int i = 0; i < 8; i++) send_word(mk(i[3:0], 16'd10 + i[15:0] % 3));
        drain();
        for (int p = 0; p < 6; p++)
        begin
            write_capacity(caps[p]);
            for (int i = 0; i < 280; i++)
            begin
                if (p == 5) quiet = (i > 200);
                send_word(rand_word(p == 0 ? 255 : 12));
            end
            drain();
        end
        quiet = 1;
        drain();
        if (sb.errors == 0 && sb.pending_words.size() == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("testbench: FAIL");
        $finish;
    end
endmodule

// ----- id_remap_lru_recycle.f -----
design/idr_pkg.sv
design/idr_ctrl.sv
design/idr_datapath.sv
design/id_remap_lru_recycle.sv
tb/testbench.sv
